@@ rtl/bost_pkg.sv @@
package bost_pkg;

  localparam int NUM_SLOTS = 2;
  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [2:0] {
    K_CLAIM_FILL  = 3'd0,
    K_BEGIN_FILL  = 3'd1,
    K_FINISH_FILL = 3'd2,
    K_CLAIM_CONS  = 3'd3,
    K_BEGIN_CONS  = 3'd4,
    K_CANCEL      = 3'd5,
    K_FINISH_CONS = 3'd6,
    K_QUERY       = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_NONE  = 3'd1,
    STS_WRONG = 3'd2,
    STS_RANGE = 3'd3,
    STS_BUSY  = 3'd4
  } sts_t;

  typedef enum logic [1:0] {
    SL_FREE     = 2'd0,
    SL_FILLING  = 2'd1,
    SL_READY    = 2'd2,
    SL_INFLIGHT = 2'd3
  } slot_st_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_FULL = 1'b1
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
  } dp_cmd_t;

endpackage

@@ rtl/bost_ctrl.sv @@
module bost_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bost_pkg::dp_cmd_t cmd
);

  bost_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bost_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    out_valid  = (state == bost_pkg::CS_FULL);
    // result slot frees up in the same cycle it is taken
    in_ready   = (state == bost_pkg::CS_IDLE) || out_ready;
    cmd.load   = in_valid && in_ready;
    state_next = state;
    unique case (state)
      bost_pkg::CS_IDLE: begin
        if (cmd.load) state_next = bost_pkg::CS_FULL;
      end
      bost_pkg::CS_FULL: begin
        if (!cmd.load && out_ready) state_next = bost_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/bost_dp.sv @@
module bost_dp (
  input  logic              clk,
  input  logic              rst,
  input  bost_pkg::dp_cmd_t cmd,
  input  logic [2:0]        kind,
  input  logic [2:0]        slot_index,
  output logic [2:0]        status,
  output logic [2:0]        result_slot,
  output logic [1:0]        slot_state,
  output logic              consumer_busy
);

  bost_pkg::slot_st_t slot_states [bost_pkg::NUM_SLOTS];
  bost_pkg::slot_st_t states_next [bost_pkg::NUM_SLOTS];

  logic                            busy, busy_next;
  logic                            free_found, ready_found;
  logic [bost_pkg::SLOT_IDX_W-1:0] free_idx, ready_idx, sel;
  logic                            in_range;
  bost_pkg::kind_t                 k;
  bost_pkg::sts_t                  sts;
  bost_pkg::slot_st_t              cur, need, nxt, rstate;
  logic [2:0]                      rslot;

  // any InFlight plus first Free / first Ready, lowest index wins
  always_comb begin
    busy        = 1'b0;
    free_found  = 1'b0;
    ready_found = 1'b0;
    free_idx    = '0;
    ready_idx   = '0;
    for (int i = bost_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_states[i] == bost_pkg::SL_INFLIGHT) busy = 1'b1;
      if (slot_states[i] == bost_pkg::SL_FREE) begin
        free_found = 1'b1;
        free_idx   = bost_pkg::SLOT_IDX_W'(i);
      end
      if (slot_states[i] == bost_pkg::SL_READY) begin
        ready_found = 1'b1;
        ready_idx   = bost_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    k           = bost_pkg::kind_t'(kind);
    sel         = slot_index[bost_pkg::SLOT_IDX_W-1:0];
    in_range    = ({1'b0, slot_index} < 4'(bost_pkg::NUM_SLOTS));
    states_next = slot_states;
    sts         = bost_pkg::STS_OK;
    rslot       = slot_index;
    rstate      = bost_pkg::SL_FREE;
    cur         = bost_pkg::SL_FREE;
    need        = bost_pkg::SL_FREE;
    nxt         = bost_pkg::SL_FREE;
    unique case (k)
      bost_pkg::K_CLAIM_FILL: begin
        rslot = '0;
        if (free_found) begin
          states_next[free_idx] = bost_pkg::SL_FILLING;
          rslot  = 3'(free_idx);
          rstate = bost_pkg::SL_FILLING;
        end else begin
          sts = bost_pkg::STS_NONE;
        end
      end
      bost_pkg::K_CLAIM_CONS: begin
        rslot = '0;
        if (busy) begin
          sts = bost_pkg::STS_BUSY;
        end else if (ready_found) begin
          states_next[ready_idx] = bost_pkg::SL_INFLIGHT;
          rslot  = 3'(ready_idx);
          rstate = bost_pkg::SL_INFLIGHT;
        end else begin
          sts = bost_pkg::STS_NONE;
        end
      end
      default: begin
        if (!in_range) begin
          sts = bost_pkg::STS_RANGE;
        end else begin
          cur = slot_states[sel];
          unique case (k)
            bost_pkg::K_BEGIN_FILL: begin
              need = bost_pkg::SL_FREE;     nxt = bost_pkg::SL_FILLING;
            end
            bost_pkg::K_FINISH_FILL: begin
              need = bost_pkg::SL_FILLING;  nxt = bost_pkg::SL_READY;
            end
            bost_pkg::K_BEGIN_CONS: begin
              need = bost_pkg::SL_READY;    nxt = bost_pkg::SL_INFLIGHT;
            end
            bost_pkg::K_CANCEL: begin
              need = bost_pkg::SL_INFLIGHT; nxt = bost_pkg::SL_READY;
            end
            bost_pkg::K_FINISH_CONS: begin
              need = bost_pkg::SL_INFLIGHT; nxt = bost_pkg::SL_FREE;
            end
            default: begin
              need = cur;                   nxt = cur;
            end
          endcase
          // state check comes before the busy check
          if (cur != need) begin
            sts    = bost_pkg::STS_WRONG;
            rstate = cur;
          end else if (k == bost_pkg::K_BEGIN_CONS && busy) begin
            sts    = bost_pkg::STS_BUSY;
            rstate = cur;
          end else begin
            states_next[sel] = nxt;
            rstate           = nxt;
          end
        end
      end
    endcase
  end

  always_comb begin
    busy_next = 1'b0;
    for (int i = 0; i < bost_pkg::NUM_SLOTS; i++) begin
      if (states_next[i] == bost_pkg::SL_INFLIGHT) busy_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bost_pkg::NUM_SLOTS; i++) begin
        slot_states[i] <= bost_pkg::SL_FREE;
      end
    end else if (cmd.load) begin
      slot_states <= states_next;
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status        <= sts;
      result_slot   <= rslot;
      slot_state    <= rstate;
      consumer_busy <= busy_next;
    end
  end

endmodule

@@ rtl/buffer_slot_ownership_tracker_unit.sv @@
// Buffer slot ownership tracker.
//
// Input channel (in_valid / in_ready): one request per event, carrying
// kind (claim fill, begin fill, finish fill, claim consumer, begin
// consumer, cancel, finish consumer, query) and slot_index.
// Output channel (out_valid / out_ready): exactly one result per request:
// status, result_slot, slot_state and consumer_busy.
//
// Latency: the request is decoded and the slot table updated at the edge
// that accepts it; the result is valid from the next cycle on, held in a
// single output register.
// Throughput: one request per cycle. in_ready stays high while the output
// register is empty or is being drained in the same cycle, so the rate is
// set by the one-entry output register.
//
// Reset (rst, synchronous): every slot goes Free and the output register
// is emptied. When the receiver stalls, the result holds and in_ready
// drops until it is taken; no request is lost or dropped.
module buffer_slot_ownership_tracker_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] kind,
  input  logic [2:0] slot_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [2:0] result_slot,
  output logic [1:0] slot_state,
  output logic       consumer_busy
);

  bost_pkg::dp_cmd_t cmd;

  // handshake control: decides when a request is taken
  bost_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // slot table, transition checks and result register
  bost_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .kind          (kind),
    .slot_index    (slot_index),
    .status        (status),
    .result_slot   (result_slot),
    .slot_state    (slot_state),
    .consumer_busy (consumer_busy)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bost_pkg::*;

  // One request as queued for the driver: gap is the number of idle
  // cycles before it is offered, hold_drain makes the sender wait until
  // every outstanding result has been returned.
  typedef struct {
    kind_t      kind;
    logic [2:0] idx;
    int         gap;
    bit         hold_drain;
  } slot_req_t;

  typedef struct {
    sts_t       status;
    logic [2:0] slot;
    slot_st_t   state;
    logic       busy;
  } slot_result_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] kind;
  logic [2:0] slot_index;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] status;
  logic [2:0] result_slot;
  logic [1:0] slot_state;
  logic       consumer_busy;

  slot_req_t    pending_reqs[$];
  slot_result_t owed_results[$];
  slot_st_t     slot_tab[NUM_SLOTS];

  int  mismatches = 0;
  int  accepted = 0;
  int  returned = 0;
  int  cyc = 0;
  int  stall_left = 0;
  int  status_seen[5];
  int  kind_sent[8];
  bit  took = 1'b0;
  bit  drain_next = 1'b0;

  buffer_slot_ownership_tracker_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .slot_index    (slot_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .result_slot   (result_slot),
    .slot_state    (slot_state),
    .consumer_busy (consumer_busy)
  );

  always #5 clk = ~clk;

  // Gap length: mostly none, some short, a few long. Calm stretches
  // force back-to-back traffic.
  function automatic int pick_gap(bit calm);
    int roll;
    roll = $urandom_range(99);
    if (calm || roll < 65) begin
      return 0;
    end
    if (roll < 93) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  function automatic bit inflight_any();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_tab[i] == SL_INFLIGHT) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Predictor: applies one event to the local slot table and returns the
  // result the block must produce for it.
  function automatic slot_result_t apply_event(kind_t k, logic [2:0] idx);
    slot_result_t r;
    slot_st_t     target;
    slot_st_t     want;
    slot_st_t     nxt;
    int           pick;
    r.status = STS_OK;
    r.slot   = idx;
    r.state  = SL_FREE;
    if (k == K_CLAIM_FILL || k == K_CLAIM_CONS) begin
      // claims ignore slot_index and report slot 0 on failure
      r.slot = '0;
      if (k == K_CLAIM_CONS && inflight_any()) begin
        r.status = STS_BUSY;
      end else begin
        target = (k == K_CLAIM_FILL) ? SL_FREE : SL_READY;
        pick = -1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (slot_tab[i] == target) begin
            pick = i;
          end
        end
        if (pick < 0) begin
          r.status = STS_NONE;
        end else begin
          slot_tab[pick] = (k == K_CLAIM_FILL) ? SL_FILLING : SL_INFLIGHT;
          r.slot  = 3'(pick);
          r.state = slot_tab[pick];
        end
      end
    end else if (idx >= NUM_SLOTS) begin
      r.status = STS_RANGE;
    end else begin
      want = slot_tab[idx];
      nxt  = slot_tab[idx];
      case (k)
        K_BEGIN_FILL: begin
          want = SL_FREE;
          nxt  = SL_FILLING;
        end
        K_FINISH_FILL: begin
          want = SL_FILLING;
          nxt  = SL_READY;
        end
        K_BEGIN_CONS: begin
          want = SL_READY;
          nxt  = SL_INFLIGHT;
        end
        K_CANCEL: begin
          want = SL_INFLIGHT;
          nxt  = SL_READY;
        end
        K_FINISH_CONS: begin
          want = SL_INFLIGHT;
          nxt  = SL_FREE;
        end
        default: begin
        end
      endcase
      // state check first, then the single-consumer rule
      if (slot_tab[idx] != want) begin
        r.status = STS_WRONG;
      end else if (k == K_BEGIN_CONS && inflight_any()) begin
        r.status = STS_BUSY;
      end else begin
        slot_tab[idx] = nxt;
      end
      r.state = slot_tab[idx];
    end
    r.busy = inflight_any();
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    if (mismatches <= 20) begin
      $display("[%0t] result %0d: %s is %0d, expected %0d", $time, returned, field, got,
               want);
    end
  endtask

  task automatic add_req(kind_t k, logic [2:0] idx, bit calm);
    slot_req_t r;
    r.kind       = k;
    r.idx        = idx;
    r.gap        = pick_gap(calm);
    r.hold_drain = drain_next;
    drain_next   = 1'b0;
    pending_reqs.push_back(r);
  endtask

  // Request side: hold until accepted, then offer the next queued request
  // after its gap.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !took)) begin
      if (pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_reqs[0].hold_drain && owed_results.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_reqs[0].gap > 0) begin
        pending_reqs[0].gap--;
        in_valid <= 1'b0;
      end else begin
        kind       <= pending_reqs[0].kind;
        slot_index <= pending_reqs[0].idx;
        in_valid   <= 1'b1;
        void'(pending_reqs.pop_front());
      end
    end
    took = 1'b0;
  end

  // Result side: random back-pressure, with calm windows every so often.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap(((cyc / 300) % 3) == 0);
    end
  end

  // Sample both handshakes at the rising edge: check returned results
  // against the oldest prediction, then predict for a newly accepted request.
  always @(posedge clk) begin : monitor
    slot_result_t exp_r;
    cyc++;
    if (!rst) begin
      if (out_valid && out_ready) begin
        returned++;
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result, status", int'(status), -1);
        end else begin
          exp_r = owed_results.pop_front();
          if (status !== exp_r.status) begin
            report_mismatch("status", int'(status), int'(exp_r.status));
          end
          if (result_slot !== exp_r.slot) begin
            report_mismatch("result_slot", int'(result_slot), int'(exp_r.slot));
          end
          if (slot_state !== exp_r.state) begin
            report_mismatch("slot_state", int'(slot_state), int'(exp_r.state));
          end
          if (consumer_busy !== exp_r.busy) begin
            report_mismatch("consumer_busy", int'(consumer_busy), int'(exp_r.busy));
          end
          if (exp_r.status <= STS_BUSY) begin
            status_seen[exp_r.status]++;
          end
        end
      end
      if (in_valid && in_ready) begin
        accepted++;
        kind_sent[kind]++;
        owed_results.push_back(apply_event(kind_t'(kind), slot_index));
        took = 1'b1;
      end
    end
  end

  initial begin
    int  n;
    int  s;
    bit  calm;
    in_valid   = 1'b0;
    out_ready  = 1'b0;
    kind       = '0;
    slot_index = '0;
    rst        = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_tab[i] = SL_FREE;
    end

    // Directed walk: empty pool, full pool, busy consumer, wrong states,
    // out-of-range indexes and ignored indexes on claims.
    add_req(K_QUERY,       3'd0, 1'b0);
    add_req(K_QUERY,       3'd7, 1'b0);
    add_req(K_CLAIM_CONS,  3'd5, 1'b0);
    add_req(K_CANCEL,      3'd0, 1'b0);
    add_req(K_FINISH_FILL, 3'd1, 1'b0);
    add_req(K_CLAIM_FILL,  3'd7, 1'b0);
    add_req(K_CLAIM_FILL,  3'd0, 1'b0);
    add_req(K_CLAIM_FILL,  3'd3, 1'b0);
    add_req(K_BEGIN_FILL,  3'd1, 1'b0);
    add_req(K_FINISH_FILL, 3'd0, 1'b0);
    add_req(K_FINISH_FILL, 3'd1, 1'b0);
    add_req(K_CLAIM_CONS,  3'd6, 1'b0);
    add_req(K_CLAIM_CONS,  3'd0, 1'b0);
    add_req(K_BEGIN_CONS,  3'd1, 1'b0);
    add_req(K_BEGIN_CONS,  3'd0, 1'b0);
    add_req(K_CANCEL,      3'd0, 1'b0);
    add_req(K_BEGIN_CONS,  3'd1, 1'b0);
    add_req(K_FINISH_CONS, 3'd1, 1'b0);
    add_req(K_FINISH_CONS, 3'd1, 1'b0);
    add_req(K_BEGIN_FILL,  3'd1, 1'b0);
    add_req(K_BEGIN_FILL,  3'd5, 1'b0);
    add_req(K_FINISH_FILL, 3'd2, 1'b0);
    add_req(K_BEGIN_CONS,  3'd4, 1'b0);
    add_req(K_CANCEL,      3'd6, 1'b0);
    add_req(K_FINISH_CONS, 3'd3, 1'b0);

    // Random part: mostly slot lifecycles with random paths, rest noise.
    // The first request after the directed walk waits for a full drain.
    drain_next = 1'b1;
    n = 0;
    while (n < 1000) begin
      calm = ((n / 100) % 3) == 2;
      if (n % 250 == 0 && n > 0) begin
        drain_next = 1'b1;
      end
      if ($urandom_range(99) < 60) begin
        s = $urandom_range(NUM_SLOTS - 1);
        if ($urandom_range(1)) begin
          add_req(K_CLAIM_FILL, 3'($urandom_range(7)), calm);
        end else begin
          add_req(K_BEGIN_FILL, 3'(s), calm);
        end
        add_req(K_FINISH_FILL, 3'(s), calm);
        n += 2;
        if ($urandom_range(3) == 0) begin
          add_req(K_QUERY, 3'(s), calm);
          n++;
        end
        if ($urandom_range(1)) begin
          add_req(K_CLAIM_CONS, 3'($urandom_range(7)), calm);
        end else begin
          add_req(K_BEGIN_CONS, 3'(s), calm);
        end
        n++;
        if ($urandom_range(3) == 0) begin
          add_req(K_CANCEL, 3'(s), calm);
          add_req(K_BEGIN_CONS, 3'(s), calm);
          n += 2;
        end
        // sometimes leave the slot in flight so later requests hit busy
        if ($urandom_range(4) != 0) begin
          add_req(K_FINISH_CONS, 3'(s), calm);
          n++;
        end
      end else begin
        add_req(kind_t'($urandom_range(7)), 3'($urandom_range(7)), calm);
        n++;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (owed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (5) @(posedge clk);

    $display("Covered %0d requests (kinds 0-7: %0d %0d %0d %0d %0d %0d %0d %0d), %0d results",
             accepted, kind_sent[0], kind_sent[1], kind_sent[2], kind_sent[3],
             kind_sent[4], kind_sent[5], kind_sent[6], kind_sent[7], returned);
    $display("Statuses ok/none/wrong/range/busy: %0d/%0d/%0d/%0d/%0d, %0d mismatches",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("Timeout with %0d results outstanding", owed_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bost_pkg.sv
rtl/bost_ctrl.sv
rtl/bost_dp.sv
rtl/buffer_slot_ownership_tracker_unit.sv
dv/testbench.sv
